// File: rtl/core/standard_array_coset_leader_builder_defines.svh
// Assertion macros shared by the coset leader builder RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef STANDARD_ARRAY_COSET_LEADER_BUILDER_DEFINES_SVH
`define STANDARD_ARRAY_COSET_LEADER_BUILDER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SCLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SCLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sclb_pkg.sv
package sclb_pkg;

    // Code geometry
    localparam int CODE_LENGTH    = 7;
    localparam int MESSAGE_LENGTH = 3;
    localparam int CHECK_LENGTH   = CODE_LENGTH - MESSAGE_LENGTH;

    localparam int VEC_W      = CODE_LENGTH;
    localparam int NUM_VEC    = 1 << VEC_W;
    localparam int MSG_W      = MESSAGE_LENGTH;
    localparam int ROW_W      = CHECK_LENGTH;
    localparam int SYN_W      = CHECK_LENGTH;
    localparam int GEN_W      = CODE_LENGTH * MESSAGE_LENGTH;
    localparam int CHK_W      = CHECK_LENGTH * CODE_LENGTH;
    localparam int CFG_W      = (GEN_W > CHK_W) ? GEN_W : CHK_W;
    localparam int HIST_DEPTH = CODE_LENGTH + 1;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int HIST_CNT_W = MSG_W + 1;
    localparam int WT_W       = $clog2(CODE_LENGTH + 2);

    // Output field widths
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 7;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHK = 1'd1;
    localparam logic [GEN_W-1:0] GEN_RESET = 21'd1122030;
    localparam logic [CHK_W-1:0] CHK_RESET = 28'd252520801;

    // Result kinds
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_HIST = 1'b1;

    // Microprogram
    localparam int PC_W = 4;

    typedef enum logic [7:0] {
        ACT_NONE      = 8'b0000_0001,
        ACT_WAIT      = 8'b0000_0010,
        ACT_CLEAR     = 8'b0000_0100,
        ACT_ROW_INIT  = 8'b0000_1000,
        ACT_SCAN      = 8'b0001_0000,
        ACT_MARK      = 8'b0010_0000,
        ACT_EMIT_ROW  = 8'b0100_0000,
        ACT_EMIT_HIST = 8'b1000_0000
    } act_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_GO,
        COND_CNT_MORE,
        COND_MSG_MORE,
        COND_ROW_ZERO,
        COND_ROW_MORE,
        COND_WT_MORE
    } cond_t;

    typedef struct packed {
        act_t            act;
        cnt_op_t         cnt_op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] STEP_CLEAR     = 4'd1;
    localparam logic [PC_W-1:0] STEP_ROW       = 4'd2;
    localparam logic [PC_W-1:0] STEP_SCAN      = 4'd3;
    localparam logic [PC_W-1:0] STEP_DRAIN     = 4'd4;
    localparam logic [PC_W-1:0] STEP_MARK      = 4'd5;
    localparam logic [PC_W-1:0] STEP_EMIT_ROW  = 4'd6;
    localparam logic [PC_W-1:0] STEP_EMIT_HIST = 4'd7;
    localparam logic [PC_W-1:0] STEP_DONE      = 4'd8;

    // Control store: taken jump goes to target, otherwise fall through
    function automatic ctrl_word_t program_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{act: ACT_NONE, cnt_op: CNT_HOLD, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:      w = '{ACT_WAIT,      CNT_CLR, COND_NO_GO,    STEP_IDLE};
            STEP_CLEAR:     w = '{ACT_CLEAR,     CNT_INC, COND_CNT_MORE, STEP_CLEAR};
            STEP_ROW:       w = '{ACT_ROW_INIT,  CNT_CLR, COND_ROW_ZERO, STEP_MARK};
            STEP_SCAN:      w = '{ACT_SCAN,      CNT_INC, COND_CNT_MORE, STEP_SCAN};
            STEP_DRAIN:     w = '{ACT_NONE,      CNT_CLR, COND_NEVER,    STEP_IDLE};
            STEP_MARK:      w = '{ACT_MARK,      CNT_INC, COND_MSG_MORE, STEP_MARK};
            STEP_EMIT_ROW:  w = '{ACT_EMIT_ROW,  CNT_CLR, COND_ROW_MORE, STEP_ROW};
            STEP_EMIT_HIST: w = '{ACT_EMIT_HIST, CNT_INC, COND_WT_MORE,  STEP_EMIT_HIST};
            STEP_DONE:      w = '{ACT_NONE,      CNT_CLR, COND_ALWAYS,   STEP_IDLE};
            default:        w = '{ACT_NONE,      CNT_CLR, COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

    // Hamming weight of a code vector
    function automatic logic [WT_W-1:0] weight_of(input logic [VEC_W-1:0] v);
        logic [WT_W-1:0] w;
        w = '0;
        for (int j = 0; j < VEC_W; j++) begin
            w = w + WT_W'(v[j]);
        end
        return w;
    endfunction

    // Codeword of a message: bit r is parity of G row r against the message
    function automatic logic [VEC_W-1:0] encode(input logic [GEN_W-1:0] g,
                                                input logic [MSG_W-1:0] msg);
        logic [VEC_W-1:0] cw;
        for (int r = 0; r < VEC_W; r++) begin
            cw[r] = ^(g[r*MSG_W +: MSG_W] & msg);
        end
        return cw;
    endfunction

    // Syndrome: bit r is parity of H row r against the vector
    function automatic logic [SYN_W-1:0] syndrome_of(input logic [CHK_W-1:0] h,
                                                     input logic [VEC_W-1:0] e);
        logic [SYN_W-1:0] s;
        for (int r = 0; r < SYN_W; r++) begin
            s[r] = ^(h[r*VEC_W +: VEC_W] & e);
        end
        return s;
    endfunction

endpackage

// File: rtl/core/sclb_ram.sv
module sclb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/standard_array_coset_leader_builder.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    go
// out       out_valid / out_ready  kind, index, value, syndrome, last
// cfg       cfg_we (no wait)       cfg_index, cfg_data
//
// A go item first clears the 128-entry used map, then for each row after row 0 runs a
// 128-entry scan of the used-map RAM (one read a cycle) and marks 8 coset members;
// row 0 only marks its members. The weight entries are emitted last.
// The used-map RAM port and the step counter of the microprogram pace this sequence.
// Reset puts the sequencer at its idle step and restores the matrix registers.
// A held output item stalls the program at its emit step; go low is taken and dropped.
`include "standard_array_coset_leader_builder_defines.svh"

module standard_array_coset_leader_builder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  go,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  kind,
    output logic [sclb_pkg::INDEX_W-1:0]          index,
    output logic [sclb_pkg::VALUE_W-1:0]          value,
    output logic [sclb_pkg::SYN_W-1:0]            syndrome,
    output logic                                  last,
    input  logic                                  cfg_we,
    input  logic [sclb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sclb_pkg::CFG_W-1:0]            cfg_data
);

    // Configuration
    logic [sclb_pkg::GEN_W-1:0] gen_reg;
    logic [sclb_pkg::CHK_W-1:0] chk_reg;

    // Sequencer and datapath state
    logic [sclb_pkg::PC_W-1:0]       pc_reg, pc_next;
    logic [sclb_pkg::VEC_W-1:0]      cnt_reg, cnt_next;
    logic [sclb_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [sclb_pkg::VEC_W-1:0]      leader_reg, leader_next;
    logic [sclb_pkg::WT_W-1:0]       best_wt_reg, best_wt_next;
    logic                            cmp_pend_reg, cmp_pend_next;
    logic [sclb_pkg::VEC_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [sclb_pkg::HIST_CNT_W-1:0] hist_reg  [sclb_pkg::HIST_DEPTH];
    logic [sclb_pkg::HIST_CNT_W-1:0] hist_next [sclb_pkg::HIST_DEPTH];

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic                         kind_reg, kind_next;
    logic [sclb_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [sclb_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [sclb_pkg::SYN_W-1:0]   syndrome_reg, syndrome_next;
    logic                         last_reg, last_next;

    // Used-map RAM
    logic                       ram_we;
    logic [sclb_pkg::VEC_W-1:0] ram_waddr;
    logic                       ram_wdata;
    logic [sclb_pkg::VEC_W-1:0] ram_raddr;
    logic                       ram_rdata;

    sclb_pkg::ctrl_word_t          word;
    logic                          emitting;
    logic                          stall;
    logic                          cond_hit;
    logic [sclb_pkg::VEC_W-1:0]    cw;
    logic [sclb_pkg::WT_W-1:0]     cw_wt;
    logic [sclb_pkg::WT_W-1:0]     cand_wt;
    logic [sclb_pkg::HIST_IDX_W-1:0] cw_wt_idx;
    logic [sclb_pkg::HIST_IDX_W-1:0] hist_idx;

    sclb_ram #(
        .WIDTH (1),
        .DEPTH (sclb_pkg::NUM_VEC)
    ) u_used_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode current step
    always_comb
    begin
        word      = sclb_pkg::program_rom(pc_reg);
        emitting  = (word.act == sclb_pkg::ACT_EMIT_ROW) ||
                    (word.act == sclb_pkg::ACT_EMIT_HIST);
        stall     = emitting && out_valid_reg && !out_ready;
        cw        = sclb_pkg::encode(gen_reg, cnt_reg[sclb_pkg::MSG_W-1:0]);
        cw_wt     = sclb_pkg::weight_of(cw);
        cw_wt_idx = cw_wt[sclb_pkg::HIST_IDX_W-1:0];
        cand_wt   = sclb_pkg::weight_of(scan_addr_reg);
        hist_idx  = cnt_reg[sclb_pkg::HIST_IDX_W-1:0];
    end

    // Evaluate jump condition
    always_comb
    begin
        unique case (word.cond)
            sclb_pkg::COND_NEVER:    cond_hit = 1'b0;
            sclb_pkg::COND_ALWAYS:   cond_hit = 1'b1;
            sclb_pkg::COND_NO_GO:    cond_hit = !(in_valid && go);
            sclb_pkg::COND_CNT_MORE: cond_hit = (cnt_reg != '1);
            sclb_pkg::COND_MSG_MORE: cond_hit = (cnt_reg[sclb_pkg::MSG_W-1:0] != '1);
            sclb_pkg::COND_ROW_ZERO: cond_hit = (row_reg == '0);
            sclb_pkg::COND_ROW_MORE: cond_hit = (row_reg != '1);
            sclb_pkg::COND_WT_MORE:
                cond_hit = (hist_idx != sclb_pkg::HIST_IDX_W'(sclb_pkg::CODE_LENGTH));
            default:                 cond_hit = 1'b0;
        endcase
    end

    assign in_ready = (word.act == sclb_pkg::ACT_WAIT);

    // Datapath next state
    always_comb
    begin
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        leader_next    = leader_reg;
        best_wt_next   = best_wt_reg;
        cmp_pend_next  = 1'b0;
        scan_addr_next = cnt_reg;
        hist_next      = hist_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        syndrome_next  = syndrome_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        ram_wdata      = 1'b0;
        ram_raddr      = cnt_reg;

        // Keep the lightest unused vector from the previous read
        if (cmp_pend_reg && !ram_rdata && (cand_wt < best_wt_reg))
        begin
            best_wt_next = cand_wt;
            leader_next  = scan_addr_reg;
        end

        if (!stall)
        begin
            pc_next = cond_hit ? word.target : pc_reg + 1'b1;

            unique case (word.cnt_op)
                sclb_pkg::CNT_HOLD: cnt_next = cnt_reg;
                sclb_pkg::CNT_INC:  cnt_next = cnt_reg + 1'b1;
                sclb_pkg::CNT_CLR:  cnt_next = '0;
                default:            cnt_next = '0;
            endcase

            unique case (word.act)
                sclb_pkg::ACT_WAIT:
                begin
                    row_next = '0;
                end
                sclb_pkg::ACT_CLEAR:
                begin
                    ram_we = 1'b1;
                    for (int i = 0; i < sclb_pkg::HIST_DEPTH; i++)
                    begin
                        hist_next[i] = '0;
                    end
                end
                sclb_pkg::ACT_ROW_INIT:
                begin
                    leader_next  = '0;
                    best_wt_next = sclb_pkg::WT_W'(sclb_pkg::CODE_LENGTH + 1);
                end
                sclb_pkg::ACT_SCAN:
                begin
                    cmp_pend_next = 1'b1;
                end
                sclb_pkg::ACT_MARK:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cw ^ leader_reg;
                    ram_wdata = 1'b1;
                    if (row_reg == '0)
                    begin
                        hist_next[cw_wt_idx] = hist_reg[cw_wt_idx] + 1'b1;
                    end
                end
                sclb_pkg::ACT_EMIT_ROW:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = sclb_pkg::KIND_ROW;
                    index_next     = sclb_pkg::INDEX_W'(row_reg);
                    value_next     = sclb_pkg::VALUE_W'(leader_reg);
                    syndrome_next  = sclb_pkg::syndrome_of(chk_reg, leader_reg);
                    last_next      = 1'b0;
                    row_next       = row_reg + 1'b1;
                end
                sclb_pkg::ACT_EMIT_HIST:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = sclb_pkg::KIND_HIST;
                    index_next     = sclb_pkg::INDEX_W'(hist_idx);
                    value_next     = sclb_pkg::VALUE_W'(hist_reg[hist_idx]);
                    syndrome_next  = '0;
                    last_next      = !cond_hit;
                end
                sclb_pkg::ACT_NONE:
                begin
                    row_next = row_reg;
                end
                default:
                begin
                    row_next = row_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= sclb_pkg::STEP_IDLE;
            cnt_reg       <= '0;
            row_reg       <= '0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gen_reg       <= sclb_pkg::GEN_RESET;
            chk_reg       <= sclb_pkg::CHK_RESET;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            cmp_pend_reg  <= cmp_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sclb_pkg::REG_GEN: gen_reg <= cfg_data[sclb_pkg::GEN_W-1:0];
                    sclb_pkg::REG_CHK: chk_reg <= cfg_data[sclb_pkg::CHK_W-1:0];
                    default:           gen_reg <= gen_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        leader_reg    <= leader_next;
        best_wt_reg   <= best_wt_next;
        scan_addr_reg <= scan_addr_next;
        hist_reg      <= hist_next;
        kind_reg      <= kind_next;
        index_reg     <= index_next;
        value_reg     <= value_next;
        syndrome_reg  <= syndrome_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign index     = index_reg;
    assign value     = value_reg;
    assign syndrome  = syndrome_reg;
    assign last      = last_reg;

    // Checks
    `SCLB_ASSERT_NOW(a_last_on_top_weight, out_valid && last,
        (kind == sclb_pkg::KIND_HIST) &&
        (index == sclb_pkg::INDEX_W'(sclb_pkg::CODE_LENGTH)),
        "last flag outside the final weight entry")
    `SCLB_ASSERT_NEXT(a_stall_holds_step, stall, pc_reg == $past(pc_reg),
        "program advanced while output item was held")
    `SCLB_ASSERT_NOW(a_row0_zero_leader,
        out_valid && (kind == sclb_pkg::KIND_ROW) && (index == '0),
        (value == '0) && (syndrome == '0),
        "row 0 leader is not the zero vector")
    `SCLB_ASSERT_NOW(a_ram_single_use, ram_we, !cmp_pend_next,
        "used map written during a scan read")

endmodule

// File: tb/coset_table_check_pkg.sv
package coset_table_check_pkg;

    import sclb_pkg::*;

    localparam int NUM_ROWS    = 1 << ROW_W;
    localparam int NUM_MSG     = 1 << MSG_W;

    // One emitted table entry, field for field as on the output ports
    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [SYN_W-1:0]   syndrome;
        logic               last;
    } table_entry_t;

    class coset_table_scoreboard;

        logic [GEN_W-1:0] gen_rows;
        logic [CHK_W-1:0] chk_rows;
        bit               used [NUM_VEC];
        int unsigned      weight_count [HIST_DEPTH];
        table_entry_t     entries_due [$];
        int unsigned      mismatches;

        function new();
            gen_rows   = GEN_RESET;
            chk_rows   = CHK_RESET;
            mismatches = 0;
        endfunction

        // Mirror a register write; upper data bits beyond the matrix are dropped
        function void set_reg(logic [CFG_IDX_W-1:0] reg_sel, logic [CFG_W-1:0] data);
            if (reg_sel == REG_GEN)
            begin
                gen_rows = data[GEN_W-1:0];
            end
            else if (reg_sel == REG_CHK)
            begin
                chk_rows = data[CHK_W-1:0];
            end
        endfunction

        function int unsigned pending();
            return entries_due.size();
        endfunction

        function void report(string what);
            mismatches++;
            $display("%0t: %s", $time, what);
        endfunction

        // Build the whole standard array for one accepted go item
        function void note_go(logic go_bit);
            logic [VEC_W-1:0] leader;
            logic [VEC_W-1:0] cw;
            logic [VEC_W-1:0] cand;
            logic [SYN_W-1:0] syn;
            int unsigned      best_w;
            bit               parity;
            if (!go_bit)
            begin
                return;
            end
            foreach (used[i])
            begin
                used[i] = 1'b0;
            end
            foreach (weight_count[i])
            begin
                weight_count[i] = 0;
            end
            for (int row = 0; row < NUM_ROWS; row++)
            begin
                // pick the lowest-index unused vector of least weight, all-ones included
                leader = '0;
                if (row != 0)
                begin
                    best_w = VEC_W + 1;
                    for (int c = 0; c < NUM_VEC; c++)
                    begin
                        cand = VEC_W'(c);
                        if (!used[c] && $countones(cand) < best_w)
                        begin
                            best_w = $countones(cand);
                            leader = cand;
                        end
                    end
                end
                // mark the coset, and count codeword weights on row 0
                for (int m = 0; m < NUM_MSG; m++)
                begin
                    for (int r = 0; r < VEC_W; r++)
                    begin
                        parity = 1'b0;
                        for (int b = 0; b < MSG_W; b++)
                        begin
                            parity ^= gen_rows[r*MSG_W+b] & m[b];
                        end
                        cw[r] = parity;
                    end
                    if (row == 0)
                    begin
                        weight_count[$countones(cw)]++;
                    end
                    used[cw ^ leader] = 1'b1;
                end
                for (int r = 0; r < SYN_W; r++)
                begin
                    parity = 1'b0;
                    for (int c = 0; c < VEC_W; c++)
                    begin
                        parity ^= chk_rows[r*VEC_W+c] & leader[c];
                    end
                    syn[r] = parity;
                end
                entries_due.push_back(table_entry_t'{KIND_ROW, INDEX_W'(row),
                                                     VALUE_W'(leader), syn, 1'b0});
            end
            for (int w = 0; w <= VEC_W; w++)
            begin
                entries_due.push_back(table_entry_t'{KIND_HIST, INDEX_W'(w),
                                                     VALUE_W'(weight_count[w]),
                                                     SYN_W'(0), (w == VEC_W)});
            end
        endfunction

        function void compare_field(string tag, string name, int unsigned want,
                                    int unsigned got);
            if (want != got)
            begin
                report($sformatf("%s %s expected %0d, got %0d", tag, name, want, got));
            end
        endfunction

        // Match one accepted output item against the oldest expected entry
        function void check_result(table_entry_t got);
            table_entry_t want;
            string        tag;
            if (entries_due.size() == 0)
            begin
                report($sformatf({"result with none expected: kind %0d index %0d",
                                  " value %0d syndrome %0d last %0d"},
                                 got.kind, got.index, got.value, got.syndrome, got.last));
                return;
            end
            want = entries_due.pop_front();
            tag  = $sformatf("%s %0d:", (want.kind == KIND_ROW) ? "row" : "weight",
                             want.index);
            compare_field(tag, "kind", want.kind, got.kind);
            compare_field(tag, "index", want.index, got.index);
            compare_field(tag, "value", want.value, got.value);
            compare_field(tag, "syndrome", want.syndrome, got.syndrome);
            compare_field(tag, "last", want.last, got.last);
        endfunction

    endclass

endpackage

// File: tb/tb_top.sv
module tb_top;

    import sclb_pkg::*;
    import coset_table_check_pkg::*;

    localparam int RUN_LIMIT = 4_000_000;
    localparam int GO_ITEMS  = 230;
    localparam int SETTLE    = 32;
    localparam int LONG_HOLD = 6000;

    typedef enum int {
        FLOW,
        COIN,
        EVERY_FOURTH,
        RARE_STALL
    } stall_mode_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               go;
    logic               out_valid;
    logic               out_ready;
    logic               kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic [SYN_W-1:0]   syndrome;
    logic               last;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    coset_table_scoreboard table_sb;
    bit                    hold_req = 1'b0;
    int unsigned           go_sent  = 0;

    standard_array_coset_leader_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .go        (go),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .index     (index),
        .value     (value),
        .syndrome  (syndrome),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one go item and hold it until the block takes it
    task automatic offer_go(input logic g);
        in_valid <= 1'b1;
        go       <= g;
        do @(posedge clk); while (!in_ready);
        table_sb.note_go(g);
        if (g)
        begin
            go_sent++;
        end
    endtask

    // Drop valid for a while; go is set to a random value meanwhile
    task automatic idle_input(input int unsigned cycles);
        if (cycles != 0)
        begin
            in_valid <= 1'b0;
            go       <= 1'($urandom_range(0, 1));
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Wait for the block to drain, then load both matrices
    task automatic load_code(input logic [CFG_W-1:0] gen, input logic [CFG_W-1:0] chk);
        in_valid <= 1'b0;
        while (table_sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GEN;
        cfg_data  <= gen;
        @(posedge clk);
        table_sb.set_reg(REG_GEN, gen);
        cfg_index <= REG_CHK;
        cfg_data  <= chk;
        @(posedge clk);
        table_sb.set_reg(REG_CHK, chk);
        cfg_we    <= 1'b0;
    endtask

    // Send bursts of mostly go items with random gaps
    task automatic run_items(input int unsigned go_wanted);
        int unsigned target;
        int unsigned burst;
        int unsigned gap;
        target = go_sent + go_wanted;
        while (go_sent < target)
        begin
            burst = $urandom_range(1, 6);
            repeat (burst)
            begin
                offer_go($urandom_range(0, 99) >= 15);
            end
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(100, 2500);
                default: gap = $urandom_range(1, 40);
            endcase
            idle_input(gap);
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_matrix(input logic [CFG_W-1:0] reset_val);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return reset_val;
            default: return CFG_W'($urandom());
        endcase
    endfunction

    // Check every output item taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            table_sb.check_result(table_entry_t'{kind, index, value, syndrome, last});
        end
    end

    // Receiver: stall pattern changes after a random span, one long hold on request
    initial
    begin : receiver
        stall_mode_t mode;
        int unsigned span;
        int unsigned tick;
        out_ready = 1'b0;
        mode      = FLOW;
        span      = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            if (span == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                span = $urandom_range(50, 400);
            end
            span--;
            tick++;
            case (mode)
                FLOW:         out_ready <= 1'b1;
                COIN:         out_ready <= 1'($urandom_range(0, 1));
                EVERY_FOURTH: out_ready <= (tick % 4 == 0);
                default:      out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Abort a hung run
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** standard_array_coset_leader_builder: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned phase;
        table_sb  = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        go        = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_GEN;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset code, go low, zero and full matrices, mixed extremes
        offer_go(1'b1);
        offer_go(1'b0);
        offer_go(1'b1);
        load_code('0, '0);
        offer_go(1'b1);
        load_code('1, '1);
        offer_go(1'b1);
        offer_go(1'b0);
        load_code('1, '0);
        offer_go(1'b1);
        load_code('0, '1);
        offer_go(1'b1);
        load_code(CFG_W'(GEN_RESET), CFG_W'(CHK_RESET));
        offer_go(1'b1);

        // Random codes; one phase holds the receiver off while go items pile up
        phase = 0;
        while (go_sent < GO_ITEMS)
        begin
            load_code(pick_matrix(CFG_W'(GEN_RESET)), pick_matrix(CFG_W'(CHK_RESET)));
            if (phase == 4)
            begin
                hold_req = 1'b1;
                repeat (4)
                begin
                    offer_go(1'b1);
                end
            end
            else
            begin
                run_items($urandom_range(3, 10));
            end
            phase++;
        end

        // Drain and let the block settle
        in_valid <= 1'b0;
        while (table_sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (table_sb.mismatches == 0)
        begin
            $display("** standard_array_coset_leader_builder: PASSED **");
        end
        else
        begin
            $display("** standard_array_coset_leader_builder: FAILED **");
        end
        $finish;
    end

endmodule
